// ===== rtl/core/point_segment_distance_core_assert.svh =====
// ----------------------------------------------------------------------------
// point_segment_distance_core_assert
// Assertion macros used by the checker file of the point segment distance core.
// ----------------------------------------------------------------------------
`ifndef POINT_SEGMENT_DISTANCE_CORE_ASSERT_SVH
`define POINT_SEGMENT_DISTANCE_CORE_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define PSD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("psd: check failed");

// Next-cycle implication, checked while out of reset.
`define PSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("psd: check failed");

`endif

// ===== rtl/core/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and constants of the point segment distance core.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int DIST_BITS = 17;

  // Per-stage pipeline control handed to each cell.
  typedef struct packed {
    logic adv;  // stage loads this cycle
    logic vld;  // valid of the beat offered to the stage
  } psd_ctl_t;

endpackage

// ===== rtl/core/point_segment_distance_core.sv =====
// ----------------------------------------------------------------------------
// point_segment_distance_core
// Floor of the distance from a point to a segment, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one beat per cycle while in_stall_o is low and returns one distance per
// beat, in order: five stages form the offsets, products, dot product, clamp
// decision and projection numerators, a row of COORD_BITS division cells
// yields the projection offsets, four stages form the squared distance, and a
// row of COORD_BITS+1 square root cells yields the root.
// Each stage holds its beat only while the stage after it is full and held,
// so empty stages keep filling while a finished result waits on the output.
// ----------------------------------------------------------------------------
module point_segment_distance_core import psd_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_BITS-1:0] point_x_i,
  input  logic [COORD_BITS-1:0] point_y_i,
  input  logic [COORD_BITS-1:0] seg_start_x_i,
  input  logic [COORD_BITS-1:0] seg_start_y_i,
  input  logic [COORD_BITS-1:0] seg_end_x_i,
  input  logic [COORD_BITS-1:0] seg_end_y_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [DIST_BITS-1:0]  distance_o
);

  localparam int C    = COORD_BITS;
  localparam int LW   = 2 * C + 1;
  localparam int SW   = 4 * C + 3;
  localparam int RW   = C + 1;
  localparam int MW   = C + 3;
  localparam int NW   = 2 * C + 2;
  localparam int DIV0 = 5;
  localparam int MID0 = DIV0 + C;
  localparam int SQ0  = MID0 + 4;
  localparam int N    = SQ0 + RW;

  // Stage control
  logic [N-1:0] vld;
  logic [N:0]   adv;
  logic [8:0]   vp_q;

  assign adv[N] = !out_stall_i;
  for (genvar k = 0; k < N; k++) begin : g_adv
    assign adv[k] = !vld[k] || adv[k+1];
  end

  for (genvar k = 0; k < 5; k++) begin : g_vh
    assign vld[k] = vp_q[k];
  end
  for (genvar k = 0; k < 4; k++) begin : g_vm
    assign vld[MID0+k] = vp_q[5+k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= '0;
    end else begin
      if (adv[0]) vp_q[0] <= in_valid_i;
      for (int k = 1; k < 5; k++) begin
        if (adv[k]) vp_q[k] <= vp_q[k-1];
      end
      if (adv[MID0]) vp_q[5] <= vld[MID0-1];
      for (int k = 1; k < 4; k++) begin
        if (adv[MID0+k]) vp_q[5+k] <= vp_q[4+k];
      end
    end
  end

  assign in_stall_o = !adv[0];

  // Stage 1: offsets
  logic signed [C-1:0] px1_q, py1_q, sx1_q, sy1_q, ex1_q, ey1_q;
  logic signed [C:0]   dx1_q, dy1_q, wx1_q, wy1_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      px1_q <= point_x_i;
      py1_q <= point_y_i;
      sx1_q <= seg_start_x_i;
      sy1_q <= seg_start_y_i;
      ex1_q <= seg_end_x_i;
      ey1_q <= seg_end_y_i;
      dx1_q <= {point_x_i[C-1], point_x_i} - {seg_start_x_i[C-1], seg_start_x_i};
      dy1_q <= {point_y_i[C-1], point_y_i} - {seg_start_y_i[C-1], seg_start_y_i};
      wx1_q <= {seg_end_x_i[C-1], seg_end_x_i} - {seg_start_x_i[C-1], seg_start_x_i};
      wy1_q <= {seg_end_y_i[C-1], seg_end_y_i} - {seg_start_y_i[C-1], seg_start_y_i};
    end
  end

  // Stage 2: products
  logic signed [C-1:0]   px2_q, py2_q, sx2_q, sy2_q, ex2_q, ey2_q;
  logic signed [C:0]     wx2_q, wy2_q;
  logic signed [2*C+1:0] pdx2_q, pdy2_q, lxx2_q, lyy2_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      px2_q  <= px1_q;
      py2_q  <= py1_q;
      sx2_q  <= sx1_q;
      sy2_q  <= sy1_q;
      ex2_q  <= ex1_q;
      ey2_q  <= ey1_q;
      wx2_q  <= wx1_q;
      wy2_q  <= wy1_q;
      pdx2_q <= dx1_q * wx1_q;
      pdy2_q <= dy1_q * wy1_q;
      lxx2_q <= wx1_q * wx1_q;
      lyy2_q <= wy1_q * wy1_q;
    end
  end

  // Stage 3: dot product and squared length
  logic signed [C-1:0]   px3_q, py3_q, sx3_q, sy3_q, ex3_q, ey3_q;
  logic signed [C:0]     wx3_q, wy3_q;
  logic signed [2*C+2:0] dot3_q;
  logic [LW-1:0]         l23_q;
  logic [2*C+1:0]        lsum;

  assign lsum = lxx2_q + lyy2_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      px3_q  <= px2_q;
      py3_q  <= py2_q;
      sx3_q  <= sx2_q;
      sy3_q  <= sy2_q;
      ex3_q  <= ex2_q;
      ey3_q  <= ey2_q;
      wx3_q  <= wx2_q;
      wy3_q  <= wy2_q;
      dot3_q <= {pdx2_q[2*C+1], pdx2_q} + {pdy2_q[2*C+1], pdy2_q};
      l23_q  <= lsum[LW-1:0];
    end
  end

  // Stage 4: clamp decision
  logic                to_start, to_end;
  logic [C:0]          absx, absy;
  logic signed [C-1:0] px4_q, py4_q, bx4_q, by4_q;
  logic [C-1:0]        mx4_q, my4_q;
  logic                nx4_q, ny4_q, useq4_q;
  logic [LW-1:0]       dotm4_q, l24_q;

  always_comb begin
    to_start = (l23_q == '0) || dot3_q[2*C+2] || (dot3_q == '0);
    to_end   = !to_start && ($signed(dot3_q) >= $signed({2'b00, l23_q}));
    absx     = wx3_q[C] ? (C+1)'(-wx3_q) : wx3_q;
    absy     = wy3_q[C] ? (C+1)'(-wy3_q) : wy3_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      px4_q   <= px3_q;
      py4_q   <= py3_q;
      bx4_q   <= to_end ? ex3_q : sx3_q;
      by4_q   <= to_end ? ey3_q : sy3_q;
      mx4_q   <= absx[C-1:0];
      my4_q   <= absy[C-1:0];
      nx4_q   <= wx3_q[C];
      ny4_q   <= wy3_q[C];
      useq4_q <= !to_start && !to_end;
      dotm4_q <= dot3_q[LW-1:0];
      l24_q   <= l23_q;
    end
  end

  // Stage 5: projection numerators
  logic [3*C:0]  numx, numy;
  logic [LW-1:0] drem_x [0:C];
  logic [LW-1:0] drem_y [0:C];
  logic [C-1:0]  dlow_x [0:C];
  logic [C-1:0]  dlow_y [0:C];
  logic [C-1:0]  dq_x   [0:C];
  logic [C-1:0]  dq_y   [0:C];
  logic [LW-1:0] dl2    [0:C];
  logic [SW-1:0] dside  [0:C];

  assign numx = mx4_q * dotm4_q;
  assign numy = my4_q * dotm4_q;

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      drem_x[0] <= numx[3*C:C];
      drem_y[0] <= numy[3*C:C];
      dlow_x[0] <= numx[C-1:0];
      dlow_y[0] <= numy[C-1:0];
      dq_x[0]   <= '0;
      dq_y[0]   <= '0;
      dl2[0]    <= l24_q;
      dside[0]  <= {px4_q, py4_q, bx4_q, by4_q, nx4_q, ny4_q, useq4_q};
    end
  end

  // Division row
  for (genvar k = 0; k < C; k++) begin : g_div
    psd_ctl_t ctl;
    assign ctl.adv = adv[DIV0+k];
    assign ctl.vld = vld[DIV0+k-1];

    psd_div_cell #(.C(C), .LW(LW), .SW(SW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .l2_i    (dl2[k]),
      .rem_x_i (drem_x[k]),
      .rem_y_i (drem_y[k]),
      .low_x_i (dlow_x[k]),
      .low_y_i (dlow_y[k]),
      .q_x_i   (dq_x[k]),
      .q_y_i   (dq_y[k]),
      .side_i  (dside[k]),
      .vld_o   (vld[DIV0+k]),
      .l2_o    (dl2[k+1]),
      .rem_x_o (drem_x[k+1]),
      .rem_y_o (drem_y[k+1]),
      .low_x_o (dlow_x[k+1]),
      .low_y_o (dlow_y[k+1]),
      .q_x_o   (dq_x[k+1]),
      .q_y_o   (dq_y[k+1]),
      .side_o  (dside[k+1])
    );
  end

  // Stage M1: projected point
  logic signed [C-1:0] spx, spy, sbx, sby;
  logic                snx, sny, suq;
  logic signed [C-1:0] px6_q, py6_q;
  logic signed [C:0]   qx6_q, qy6_q;

  assign {spx, spy, sbx, sby, snx, sny, suq} = dside[C];

  always_ff @(posedge clk_i) begin
    if (adv[MID0]) begin
      px6_q <= spx;
      py6_q <= spy;
      if (!suq) begin
        qx6_q <= {sbx[C-1], sbx};
        qy6_q <= {sby[C-1], sby};
      end else begin
        qx6_q <= snx ? {sbx[C-1], sbx} - {1'b0, dq_x[C]} : {sbx[C-1], sbx} + {1'b0, dq_x[C]};
        qy6_q <= sny ? {sby[C-1], sby} - {1'b0, dq_y[C]} : {sby[C-1], sby} + {1'b0, dq_y[C]};
      end
    end
  end

  // Stage M2: distance offsets
  logic signed [C+1:0] ddx7_q, ddy7_q;

  always_ff @(posedge clk_i) begin
    if (adv[MID0+1]) begin
      ddx7_q <= {{2{px6_q[C-1]}}, px6_q} - {qx6_q[C], qx6_q};
      ddy7_q <= {{2{py6_q[C-1]}}, py6_q} - {qy6_q[C], qy6_q};
    end
  end

  // Stage M3: squares
  logic signed [2*C+3:0] sqx8_q, sqy8_q;

  always_ff @(posedge clk_i) begin
    if (adv[MID0+2]) begin
      sqx8_q <= ddx7_q * ddx7_q;
      sqy8_q <= ddy7_q * ddy7_q;
    end
  end

  // Stage M4: squared distance, root row seed
  logic [MW-1:0] srem  [0:RW];
  logic [RW-1:0] sroot [0:RW];
  logic [NW-1:0] sn    [0:RW];

  always_ff @(posedge clk_i) begin
    if (adv[MID0+3]) begin
      srem[0]  <= '0;
      sroot[0] <= '0;
      sn[0]    <= sqx8_q[NW-1:0] + sqy8_q[NW-1:0];
    end
  end

  // Square root row
  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    psd_ctl_t ctl;
    assign ctl.adv = adv[SQ0+j];
    assign ctl.vld = vld[SQ0+j-1];

    psd_sqrt_cell #(.C(C), .RW(RW), .MW(MW), .NW(NW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .rem_i  (srem[j]),
      .root_i (sroot[j]),
      .n_i    (sn[j]),
      .vld_o  (vld[SQ0+j]),
      .rem_o  (srem[j+1]),
      .root_o (sroot[j+1]),
      .n_o    (sn[j+1])
    );
  end

  logic [DIST_BITS+RW-1:0] root_ext;

  assign root_ext    = {{DIST_BITS{1'b0}}, sroot[RW]};
  assign distance_o  = root_ext[DIST_BITS-1:0];
  assign out_valid_o = vld[N-1];

endmodule

// ===== rtl/core/psd_div_cell.sv =====
// ----------------------------------------------------------------------------
// psd_div_cell
// One restoring division step for the x and y lanes, with side data.
// ----------------------------------------------------------------------------
module psd_div_cell import psd_pkg::*; #(
  parameter int C  = 16,
  parameter int LW = 2 * C + 1,
  parameter int SW = 4 * C + 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  psd_ctl_t      ctl_i,
  input  logic [LW-1:0] l2_i,
  input  logic [LW-1:0] rem_x_i,
  input  logic [LW-1:0] rem_y_i,
  input  logic [C-1:0]  low_x_i,
  input  logic [C-1:0]  low_y_i,
  input  logic [C-1:0]  q_x_i,
  input  logic [C-1:0]  q_y_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [LW-1:0] l2_o,
  output logic [LW-1:0] rem_x_o,
  output logic [LW-1:0] rem_y_o,
  output logic [C-1:0]  low_x_o,
  output logic [C-1:0]  low_y_o,
  output logic [C-1:0]  q_x_o,
  output logic [C-1:0]  q_y_o,
  output logic [SW-1:0] side_o
);

  logic [LW:0]   rx2, ry2;
  logic          bx, by;
  logic [LW-1:0] rem_x_d, rem_y_d;
  logic          vld_q;

  always_comb begin
    rx2 = {rem_x_i, low_x_i[C-1]};
    ry2 = {rem_y_i, low_y_i[C-1]};
    bx  = rx2 >= {1'b0, l2_i};
    by  = ry2 >= {1'b0, l2_i};
    rem_x_d = bx ? LW'(rx2 - {1'b0, l2_i}) : rx2[LW-1:0];
    rem_y_d = by ? LW'(ry2 - {1'b0, l2_i}) : ry2[LW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.adv) begin
      vld_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      l2_o    <= l2_i;
      rem_x_o <= rem_x_d;
      rem_y_o <= rem_y_d;
      low_x_o <= {low_x_i[C-2:0], 1'b0};
      low_y_o <= {low_y_i[C-2:0], 1'b0};
      q_x_o   <= {q_x_i[C-2:0], bx};
      q_y_o   <= {q_y_i[C-2:0], by};
      side_o  <= side_i;
    end
  end

  assign vld_o = vld_q;

endmodule

// ===== rtl/core/psd_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// psd_sqrt_cell
// One digit-by-digit integer square root step: two radicand bits, one root bit.
// ----------------------------------------------------------------------------
module psd_sqrt_cell import psd_pkg::*; #(
  parameter int C  = 16,
  parameter int RW = C + 1,
  parameter int MW = C + 3,
  parameter int NW = 2 * C + 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  psd_ctl_t      ctl_i,
  input  logic [MW-1:0] rem_i,
  input  logic [RW-1:0] root_i,
  input  logic [NW-1:0] n_i,
  output logic          vld_o,
  output logic [MW-1:0] rem_o,
  output logic [RW-1:0] root_o,
  output logic [NW-1:0] n_o
);

  logic [MW+1:0] rem2, trial;
  logic          take;
  logic          vld_q;

  always_comb begin
    rem2  = {rem_i, n_i[NW-1:NW-2]};
    trial = (MW+2)'({root_i, 2'b01});
    take  = rem2 >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.adv) begin
      vld_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      rem_o  <= take ? MW'(rem2 - trial) : rem2[MW-1:0];
      root_o <= {root_i[RW-2:0], take};
      n_o    <= {n_i[NW-3:0], 2'b00};
    end
  end

  assign vld_o = vld_q;

endmodule

// ===== rtl/core/point_segment_distance_core_checker.sv =====
// ----------------------------------------------------------------------------
// point_segment_distance_core_checker
// Port-level checks of the point segment distance core, bound to the top.
// ----------------------------------------------------------------------------
`include "point_segment_distance_core_assert.svh"

module point_segment_distance_core_checker import psd_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [DIST_BITS-1:0] distance_o
);

  // A held result keeps its beat.
  `PSD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(distance_o))

  // Input backs up only when the whole pipe is full behind a held result.
  `PSD_ASSERT_NOW(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)

  // A full pipe stays full while the output is held; input stall then follows the output.
  `PSD_ASSERT_NEXT(a_full_hold, in_stall_o && out_stall_i, in_stall_o == out_stall_i)

endmodule

bind point_segment_distance_core point_segment_distance_core_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .distance_o  (distance_o)
);
